// ===== rtl/core/lfps_pkg.sv =====
package lfps_pkg;

  // Defaults for the top level parameters
  localparam int unsigned SENSOR_COUNT_DEF = 8;
  localparam int unsigned LOST_TIMEOUT_DEF = 100;

  // Fixed-point format, search threshold and integral limit
  localparam int unsigned FRAC_BITS      = 8;
  localparam int unsigned GAIN_FRAC      = 8;
  localparam int unsigned LOST_MIN_ERROR = 64;
  localparam int unsigned INTEGRAL_LIMIT = 10 << FRAC_BITS;

  // Field and register widths
  localparam int unsigned ERR_W      = 12;
  localparam int unsigned INTEG_W    = 13;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CENTER_W   = 11;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Multiply-accumulate widths
  localparam int unsigned OP_W    = 13;
  localparam int unsigned PROD_W  = GAIN_W + OP_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned SHIFT_W = GAIN_FRAC + FRAC_BITS;
  localparam int unsigned CORR_W  = ACC_W - SHIFT_W;
  localparam int unsigned SUMV_W  = CORR_W + 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_CENTER       = 3'd3,
    CFG_BASE_SPEED   = 3'd4,
    CFG_MIN_SPEED    = 3'd5,
    CFG_MAX_SPEED    = 3'd6,
    CFG_SEARCH_SPEED = 3'd7
  } cfg_idx_e;

  // Operand select of the shared multiplier
  typedef enum logic [1:0] {
    MAC_P,
    MAC_D,
    MAC_I
  } mac_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     div_step;
    logic     err_upd;
    logic     mul_en;
    mac_sel_e mac_sel;
    logic     acc_clr;
    logic     acc_add;
    logic     spd_upd;
    logic     lost_upd;
    logic     out_load;
  } lfps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic line_seen;
    logic out_free;
  } lfps_sts_t;

endpackage

// ===== rtl/core/lfps_ctrl.sv =====
module lfps_ctrl import lfps_pkg::*; #(
  parameter int unsigned DIV_STEPS = 13
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lfps_sts_t sts_i,
  output lfps_cmd_t cmd_o
);

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_ERROR,
    S_MUL_P,
    S_MUL_D,
    S_MUL_I,
    S_ACCUM,
    S_SPEED,
    S_LOST,
    S_RESULT
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.mac_sel = MAC_P;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        step_d  = '0;
        state_d = sts_i.line_seen ? S_DIVIDE : S_LOST;
      end
      S_DIVIDE: begin
        // one quotient bit per cycle
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_ERROR;
        end
      end
      S_ERROR: begin
        cmd_o.err_upd = 1'b1;
        state_d       = S_MUL_P;
      end
      S_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mac_sel = MAC_P;
        cmd_o.acc_clr = 1'b1;
        state_d       = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mac_sel = MAC_D;
        cmd_o.acc_add = 1'b1;
        state_d       = S_MUL_I;
      end
      S_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mac_sel = MAC_I;
        cmd_o.acc_add = 1'b1;
        state_d       = S_ACCUM;
      end
      S_ACCUM: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_SPEED;
      end
      S_SPEED: begin
        cmd_o.spd_upd = 1'b1;
        state_d       = S_RESULT;
      end
      S_LOST: begin
        cmd_o.lost_upd = 1'b1;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        // wait for room in the output register
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== rtl/core/lfps_datapath.sv =====
module lfps_datapath import lfps_pkg::*; #(
  parameter int unsigned SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int unsigned LOST_TIMEOUT = LOST_TIMEOUT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            sensor_bits_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SPEED_W-1:0]    left_wheel_o,
  output logic [SPEED_W-1:0]    right_wheel_o,
  output logic                  line_lost_o,
  input  lfps_cmd_t             cmd_i,
  output lfps_sts_t             sts_o
);

  localparam int unsigned SUM_W  = $clog2(SENSOR_COUNT * (SENSOR_COUNT - 1) / 2 + 1);
  localparam int unsigned CNT_W  = $clog2(SENSOR_COUNT + 1);
  localparam int unsigned DVD_W  = SUM_W + FRAC_BITS;
  localparam int unsigned LOST_W = $clog2(LOST_TIMEOUT + 1);

  localparam logic signed [INTEG_W:0] ILIM_P = (INTEG_W + 1)'(INTEGRAL_LIMIT);
  localparam logic signed [INTEG_W:0] ILIM_N = -ILIM_P;
  localparam logic signed [ERR_W-1:0] SRCH_P = ERR_W'(LOST_MIN_ERROR);
  localparam logic signed [ERR_W-1:0] SRCH_N = -SRCH_P;

  // Configuration registers
  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [CENTER_W-1:0]      center_q;
  logic [SPEED_W-1:0]       base_q, min_q, max_q, search_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      center_q <= CENTER_W'(896);
      base_q   <= '0;
      min_q    <= '0;
      max_q    <= '1;
      search_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_P:       gain_p_q <= cfg_data_i;
        CFG_GAIN_I:       gain_i_q <= cfg_data_i;
        CFG_GAIN_D:       gain_d_q <= cfg_data_i;
        CFG_CENTER:       center_q <= cfg_data_i[CENTER_W-1:0];
        CFG_BASE_SPEED:   base_q   <= cfg_data_i[SPEED_W-1:0];
        CFG_MIN_SPEED:    min_q    <= cfg_data_i[SPEED_W-1:0];
        CFG_MAX_SPEED:    max_q    <= cfg_data_i[SPEED_W-1:0];
        CFG_SEARCH_SPEED: search_q <= cfg_data_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Index sum and count of the sensors that see the line
  logic [SUM_W-1:0] sum_c;
  logic [CNT_W-1:0] cnt_c;

  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (!sensor_bits_i[i]) begin
        sum_c = sum_c + SUM_W'(i);
        cnt_c = cnt_c + CNT_W'(1);
      end
    end
  end

  // Restoring divider: position = (sum << FRAC_BITS) / count
  logic [DVD_W-1:0] quo_q;
  logic [CNT_W-1:0] rem_q, cnt_q;
  logic [CNT_W:0]   rem_sh;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      quo_q <= DVD_W'(sum_c) << FRAC_BITS;
      rem_q <= '0;
      cnt_q <= cnt_c;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, cnt_q}) begin
        rem_q <= CNT_W'(rem_sh - {1'b0, cnt_q});
        quo_q <= {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[CNT_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign sts_o.line_seen = (cnt_q != '0);

  // Error, derivative and clamped integral
  logic signed [ERR_W:0]     err_w;
  logic signed [ERR_W-1:0]   err_c;
  logic signed [INTEG_W:0]   isum_c;
  logic signed [INTEG_W-1:0] integ_c;
  logic signed [ERR_W-1:0]   prev_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [OP_W-1:0]    diff_q;
  logic [LOST_W-1:0]         lost_cnt_q;
  logic [LOST_W-1:0]         lost_cnt_c;

  assign err_w  = $signed((ERR_W + 1)'(quo_q)) - $signed((ERR_W + 1)'(center_q));
  assign err_c  = err_w[ERR_W-1:0];
  assign isum_c = (INTEG_W + 1)'(integ_q) + (INTEG_W + 1)'(err_c);

  always_comb begin
    if (isum_c > ILIM_P) begin
      integ_c = ILIM_P[INTEG_W-1:0];
    end else if (isum_c < ILIM_N) begin
      integ_c = ILIM_N[INTEG_W-1:0];
    end else begin
      integ_c = isum_c[INTEG_W-1:0];
    end
  end

  // Saturating count of lost ticks
  assign lost_cnt_c = (lost_cnt_q < LOST_W'(LOST_TIMEOUT)) ? lost_cnt_q + LOST_W'(1)
                                                            : lost_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      integ_q    <= '0;
      lost_cnt_q <= '0;
    end else if (cmd_i.err_upd) begin
      prev_q     <= err_c;
      integ_q    <= integ_c;
      lost_cnt_q <= '0;
    end else if (cmd_i.lost_upd) begin
      integ_q    <= '0;
      lost_cnt_q <= lost_cnt_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_upd) begin
      diff_q <= OP_W'(err_c) - OP_W'(prev_q);
    end
  end

  // Shared multiplier with accumulator
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  always_comb begin
    case (cmd_i.mac_sel)
      MAC_P: begin
        mul_a = gain_p_q;
        mul_b = OP_W'(prev_q);
      end
      MAC_D: begin
        mul_a = gain_d_q;
        mul_b = diff_q;
      end
      MAC_I: begin
        mul_a = gain_i_q;
        mul_b = integ_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Correction truncated toward zero, then wheel clamps
  logic signed [ACC_W-1:0]  acc_adj;
  logic signed [CORR_W-1:0] corr_c;
  logic signed [SUMV_W-1:0] base_s, min_s, max_s, left_v, right_v;
  logic [SPEED_W-1:0]       left_c, right_c;

  assign acc_adj = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << SHIFT_W) - 1) : ACC_W'(0));
  assign corr_c  = acc_adj[ACC_W-1:SHIFT_W];
  assign base_s  = SUMV_W'(base_q);
  assign min_s   = SUMV_W'(min_q);
  assign max_s   = SUMV_W'(max_q);
  assign left_v  = base_s + SUMV_W'(corr_c);
  assign right_v = base_s - SUMV_W'(corr_c);

  always_comb begin
    if (left_v < min_s) begin
      left_c = min_q;
    end else if (left_v > max_s) begin
      left_c = max_q;
    end else begin
      left_c = left_v[SPEED_W-1:0];
    end
    if (right_v < min_s) begin
      right_c = min_q;
    end else if (right_v > max_s) begin
      right_c = max_q;
    end else begin
      right_c = right_v[SPEED_W-1:0];
    end
  end

  // Finished result, held until the output register has room
  logic [SPEED_W-1:0] res_left_q, res_right_q;
  logic               res_lost_q;
  logic               searching;

  assign searching = (lost_cnt_c < LOST_W'(LOST_TIMEOUT));

  always_ff @(posedge clk_i) begin
    if (cmd_i.spd_upd) begin
      res_left_q  <= left_c;
      res_right_q <= right_c;
      res_lost_q  <= 1'b0;
    end else if (cmd_i.lost_upd) begin
      res_left_q  <= (searching && (prev_q > SRCH_P)) ? search_q : '0;
      res_right_q <= (searching && !(prev_q > SRCH_P) && (prev_q < SRCH_N)) ? search_q : '0;
      res_lost_q  <= 1'b1;
    end
  end

  // Output register
  logic               out_valid_q;
  logic [SPEED_W-1:0] out_left_q, out_right_q;
  logic               out_lost_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_left_q  <= res_left_q;
      out_right_q <= res_right_q;
      out_lost_q  <= res_lost_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_wheel_o  = out_left_q;
  assign right_wheel_o = out_right_q;
  assign line_lost_o   = out_lost_q;

  // Checks
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= ILIM_P) && (integ_q >= ILIM_N))
    else $error("integral outside its clamp");

  a_lost_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_cnt_q <= LOST_W'(LOST_TIMEOUT))
    else $error("lost counter beyond timeout");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  a_search_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && res_lost_q) |=> !((left_wheel_o != '0) && (right_wheel_o != '0)))
    else $error("both wheels driven while searching");

endmodule

// ===== rtl/core/line_follow_pid_steer_unit.sv =====
// PID line follower for a two-wheel drive. Each input transaction carries one
// sensor vector (a cleared bit sees the line); each produces exactly one output
// transaction with the left and right wheel speeds and a line-lost flag. One
// transaction is processed at a time. On a tracking tick a restoring divider
// forms the line position one quotient bit per cycle, and the P, I and D
// terms share a single multiplier; a lost-line tick skips both. The next
// transaction is accepted, at the earliest, once a result has entered the
// output register and the block is idle again. A stalled result waits in the
// output register, so the next transaction can be accepted and processed
// meanwhile. Configuration writes take effect on the next clock and must only
// be issued while the block is idle.
module line_follow_pid_steer_unit import lfps_pkg::*; #(
  parameter int unsigned SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int unsigned LOST_TIMEOUT = LOST_TIMEOUT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            sensor_bits_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SPEED_W-1:0]    left_wheel_o,
  output logic [SPEED_W-1:0]    right_wheel_o,
  output logic                  line_lost_o
);

  localparam int unsigned DIV_STEPS =
    $clog2(SENSOR_COUNT * (SENSOR_COUNT - 1) / 2 + 1) + FRAC_BITS;

  lfps_cmd_t cmd;
  lfps_sts_t sts;

  lfps_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfps_datapath #(
    .SENSOR_COUNT (SENSOR_COUNT),
    .LOST_TIMEOUT (LOST_TIMEOUT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sensor_bits_i (sensor_bits_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_wheel_o  (left_wheel_o),
    .right_wheel_o (right_wheel_o),
    .line_lost_o   (line_lost_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
